// ----- rtl/sdiv_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sdiv_pkg
// Shared widths, status codes and pipeline payload types of the signed
// 64-by-32 divider.
// -----------------------------------------------------------------------------
package sdiv_pkg;

  localparam int unsigned SDIV_DIVIDEND_W      = 64;
  localparam int unsigned SDIV_DIVISOR_W       = 32;
  localparam int unsigned SDIV_QUOTIENT_W      = 32;
  localparam int unsigned SDIV_STATUS_W        = 2;
  // Quotient magnitude bits left to resolve once overflow is ruled out.
  localparam int unsigned SDIV_QBITS           = 31;
  localparam int unsigned SDIV_STEPS_PER_STAGE = 2;

  typedef enum logic [SDIV_STATUS_W-1:0] {
    SDIV_OK       = 2'd0,
    SDIV_DIV_ZERO = 2'd1,
    SDIV_OVERFLOW = 2'd2
  } sdiv_status_e;

  // Operand magnitudes after the first stage.
  typedef struct packed {
    logic [SDIV_DIVIDEND_W-1:0] xmag;
    logic [SDIV_DIVISOR_W-1:0]  ymag;
    logic                       neg;
    logic                       zero;
  } sdiv_mag_t;

  // Working set of the long division: partial remainder, and a shift register
  // that loses dividend bits at the top and gains quotient bits at the bottom.
  typedef struct packed {
    logic [SDIV_DIVISOR_W-1:0] rem;
    logic [SDIV_QBITS-1:0]     bits;
    logic [SDIV_DIVISOR_W-1:0] ymag;
    logic                      neg;
    sdiv_status_e              status;
  } sdiv_work_t;

endpackage

// ----- rtl/sdiv_intf.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sdiv_intf
// Valid/ready channels of the divider: operand pair in, quotient and status
// out.
// -----------------------------------------------------------------------------
interface sdiv_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [sdiv_pkg::SDIV_DIVIDEND_W-1:0] dividend;
  logic signed [sdiv_pkg::SDIV_DIVISOR_W-1:0]  divisor;

  modport source (output valid, dividend, divisor, input ready);
  modport sink   (input valid, dividend, divisor, output ready);
endinterface

interface sdiv_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [sdiv_pkg::SDIV_QUOTIENT_W-1:0] quotient;
  logic        [sdiv_pkg::SDIV_STATUS_W-1:0]   status;

  modport source (output valid, quotient, status, input ready);
  modport sink   (input valid, quotient, status, output ready);
endinterface

// ----- rtl/sdiv_front.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sdiv_front
// Two pipeline stages: operand magnitudes and sign, then divide-by-zero and
// overflow checks and the initial partial remainder.
// -----------------------------------------------------------------------------
module sdiv_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sdiv_in_if.sink              req_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output sdiv_pkg::sdiv_work_t work_o
);

  localparam int unsigned XW = sdiv_pkg::SDIV_DIVIDEND_W;
  localparam int unsigned YW = sdiv_pkg::SDIV_DIVISOR_W;
  localparam int unsigned QB = sdiv_pkg::SDIV_QBITS;

  logic                 a_valid_q;
  logic                 a_ready;
  sdiv_pkg::sdiv_mag_t  a_d, a_q;
  logic                 b_valid_q;
  logic                 b_ready;
  sdiv_pkg::sdiv_work_t b_d, b_q;
  logic [YW:0]          x_hi;

  assign b_ready     = !b_valid_q || ready_i;
  assign a_ready     = !a_valid_q || b_ready;
  assign req_i.ready = a_ready;

  // Stage A: magnitudes. The most negative dividend maps to 2^63 unsigned.
  always_comb begin
    a_d.neg  = req_i.dividend[XW-1] ^ req_i.divisor[YW-1];
    a_d.zero = (req_i.divisor == '0);
    a_d.xmag = req_i.dividend[XW-1] ? (~req_i.dividend + XW'(1)) : req_i.dividend;
    a_d.ymag = req_i.divisor[YW-1] ? (~req_i.divisor + YW'(1)) : req_i.divisor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && a_ready) begin
      a_q <= a_d;
    end
  end

  // Stage B: the quotient fits 31 bits exactly when the top 33 dividend bits
  // are below the divisor; those bits are then the first partial remainder.
  assign x_hi = a_q.xmag[XW-1 -: YW+1];

  always_comb begin
    b_d.rem  = x_hi[YW-1:0];
    b_d.bits = a_q.xmag[QB-1:0];
    b_d.ymag = a_q.ymag;
    b_d.neg  = a_q.neg;
    if (a_q.zero) begin
      b_d.status = sdiv_pkg::SDIV_DIV_ZERO;
    end else if (x_hi >= {1'b0, a_q.ymag}) begin
      b_d.status = sdiv_pkg::SDIV_OVERFLOW;
    end else begin
      b_d.status = sdiv_pkg::SDIV_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign work_o  = b_q;

endmodule

// ----- rtl/sdiv_step.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sdiv_step
// One restoring-division pipeline stage: StepsPerStage shift-compare-subtract
// steps on the partial remainder, each producing one quotient bit.
// -----------------------------------------------------------------------------
module sdiv_step #(
  parameter int unsigned FirstStep     = 0,
  parameter int unsigned StepsPerStage = sdiv_pkg::SDIV_STEPS_PER_STAGE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  sdiv_pkg::sdiv_work_t work_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output sdiv_pkg::sdiv_work_t work_o
);

  localparam int unsigned YW = sdiv_pkg::SDIV_DIVISOR_W;
  localparam int unsigned QB = sdiv_pkg::SDIV_QBITS;

  logic                 valid_q;
  sdiv_pkg::sdiv_work_t work_d, work_q;
  logic [YW:0]          trial;
  logic [YW:0]          diff;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    work_d = work_i;
    trial  = '0;
    diff   = '0;
    for (int unsigned j = 0; j < StepsPerStage; j++) begin
      // The last stage may have fewer quotient bits left than steps.
      if (FirstStep + j < QB) begin
        trial = {work_d.rem, work_d.bits[QB-1]};
        diff  = trial - {1'b0, work_d.ymag};
        if (trial >= {1'b0, work_d.ymag}) begin
          work_d.rem  = diff[YW-1:0];
          work_d.bits = {work_d.bits[QB-2:0], 1'b1};
        end else begin
          work_d.rem  = trial[YW-1:0];
          work_d.bits = {work_d.bits[QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ----- rtl/sdiv_back.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sdiv_back
// Output stage: applies the quotient sign, forces zero on errors and holds the
// result until the receiver takes it.
// -----------------------------------------------------------------------------
module sdiv_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  sdiv_pkg::sdiv_work_t work_i,
  sdiv_out_if.source           rsp_o
);

  localparam int unsigned QW = sdiv_pkg::SDIV_QUOTIENT_W;

  logic                   valid_q;
  logic [QW-1:0]          mag;
  logic [QW-1:0]          quot_d, quot_q;
  sdiv_pkg::sdiv_status_e status_q;

  assign ready_o = !valid_q || rsp_o.ready;
  assign mag     = {1'b0, work_i.bits};

  always_comb begin
    if (work_i.status != sdiv_pkg::SDIV_OK) begin
      quot_d = '0;
    end else if (work_i.neg) begin
      quot_d = ~mag + QW'(1);
    end else begin
      quot_d = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      quot_q   <= quot_d;
      status_q <= work_i.status;
    end
  end

  assign rsp_o.valid    = valid_q;
  assign rsp_o.quotient = quot_q;
  assign rsp_o.status   = status_q;

endmodule

// ----- rtl/signed_div_64_by_32_quotient.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// signed_div_64_by_32_quotient
// Pipelined signed 64-by-32 divider returning the quotient truncated toward
// zero, with divide-by-zero and overflow reported in a status code.
//
// Usage:
// - req_i carries a dividend/divisor pair; rsp_o returns quotient and status
//   (0 ok, 1 divide by zero, 2 overflow when the quotient magnitude is 2^31 or
//   more). On an error the quotient is 0. Every transaction on req_i yields
//   exactly one transaction on rsp_o, in order.
// - From acceptance to rsp_o.valid a transaction passes, in order, the stages
//   magnitudes, range check, the division stages (two division steps per stage
//   by default), sign and output.
// - One transaction per cycle unless rsp_o stalls; each division stage resolves
//   STEPS_PER_STAGE quotient bits with chained 33-bit compare-subtracts.
// - Each stage advances when its successor is empty or moving, so bubbles are
//   squeezed out. When rsp_o stalls, results back up stage by stage and
//   req_i.ready drops only once every stage holds a transaction.
// - Reset clears all stage valid bits; no transaction is in flight after it.
// -----------------------------------------------------------------------------
module signed_div_64_by_32_quotient #(
  parameter int unsigned STEPS_PER_STAGE = sdiv_pkg::SDIV_STEPS_PER_STAGE
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdiv_in_if.sink    req_i,
  sdiv_out_if.source rsp_o
);

  localparam int unsigned NumStages =
    (sdiv_pkg::SDIV_QBITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic [NumStages:0]   stg_valid;
  logic [NumStages:0]   stg_ready;
  sdiv_pkg::sdiv_work_t stg_work [NumStages+1];

  sdiv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .work_o  (stg_work[0])
  );

  for (genvar k = 0; k < NumStages; k++) begin : g_step
    sdiv_step #(
      .FirstStep     (k * STEPS_PER_STAGE),
      .StepsPerStage (STEPS_PER_STAGE)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .work_i  (stg_work[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .work_o  (stg_work[k+1])
    );
  end

  sdiv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[NumStages]),
    .ready_o (stg_ready[NumStages]),
    .work_i  (stg_work[NumStages]),
    .rsp_o   (rsp_o)
  );

  // Status is one of the three defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.status == sdiv_pkg::SDIV_OK ||
                     rsp_o.status == sdiv_pkg::SDIV_DIV_ZERO ||
                     rsp_o.status == sdiv_pkg::SDIV_OVERFLOW))
    else $error("sdiv: undefined status code");

  // Errors always return a zero quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != sdiv_pkg::SDIV_OK) |-> (rsp_o.quotient == '0))
    else $error("sdiv: nonzero quotient on error");

  // A good quotient never reaches -2^31; that case belongs to overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == sdiv_pkg::SDIV_OK) |->
      (rsp_o.quotient != {1'b1, {(sdiv_pkg::SDIV_QUOTIENT_W-1){1'b0}}}))
    else $error("sdiv: quotient out of range");

  // Input backpressure only when the whole pipe is full behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (rsp_o.valid && !rsp_o.ready && (&stg_valid)))
    else $error("sdiv: input stalled with room in the pipeline");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined signed 64-by-32 quotient divider.
// Operand pairs go in on the request channel, and each expected quotient and
// status is computed in the bench and queued. Every response is compared in
// order. Phases: directed corner cases, back-to-back streaming, random gaps on
// both channels, a long response hold-off that fills the pipe, one-sided gaps.
// -----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic signed [sdiv_pkg::SDIV_QUOTIENT_W-1:0] quotient;
    sdiv_pkg::sdiv_status_e                      status;
  } quot_res_t;

  logic clk;
  logic rst_n;

  sdiv_in_if  req_if ();
  sdiv_out_if rsp_if ();

  signed_div_64_by_32_quotient uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  quot_res_t quot_q[$];
  int unsigned pairs_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned ok_cnt       = 0;
  int unsigned div_zero_cnt = 0;
  int unsigned overflow_cnt = 0;
  int unsigned req_stall_cycles = 0;

  bit tx_gaps_en = 1'b0;
  bit rx_gaps_en = 1'b0;
  int unsigned rx_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected quotient and status for one operand pair.
  function automatic quot_res_t predict_quotient(logic signed [63:0] num,
                                                 logic signed [31:0] den);
    logic [63:0] num_mag;
    logic [31:0] den_abs;
    logic [63:0] q_mag;
    quot_res_t   res;
    num_mag = num[63] ? (~num + 64'd1) : num;
    den_abs = den[31] ? (~den + 32'd1) : den;
    res.quotient = '0;
    if (den_abs == 32'd0) begin
      res.status = sdiv_pkg::SDIV_DIV_ZERO;
    end else begin
      q_mag = num_mag / {32'd0, den_abs};
      if (q_mag >= 64'h0000_0000_8000_0000) begin
        res.status = sdiv_pkg::SDIV_OVERFLOW;
      end else begin
        res.status   = sdiv_pkg::SDIV_OK;
        res.quotient = (num[63] ^ den[31]) ? -q_mag[31:0] : q_mag[31:0];
      end
    end
    return res;
  endfunction

  task automatic send_pair(input logic signed [63:0] num, input logic signed [31:0] den);
    int unsigned gap;
    gap = tx_gaps_en ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.dividend = num;
    req_if.divisor  = den;
    req_if.valid    = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    quot_q.push_back(predict_quotient(num, den));
    pairs_sent++;
  endtask

  // Mostly pairs whose quotient fits, built as q * d + r, plus pairs near the
  // overflow edge, raw random pairs and zero divisors.
  task automatic send_random_pair();
    logic [31:0] q_mag;
    logic [31:0] d_abs;
    logic [63:0] r_mag;
    logic [63:0] x_mag;
    logic        x_neg;
    logic        y_neg;
    logic signed [63:0] num;
    logic signed [31:0] den;
    int unsigned kind;
    kind  = $urandom_range(0, 99);
    x_neg = 1'($urandom_range(0, 1));
    y_neg = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) begin
      d_abs = 32'h8000_0000;
      y_neg = 1'b1;
    end else begin
      d_abs = $urandom >> (32 - $urandom_range(1, 31));
      if (d_abs == 32'd0) d_abs = 32'd1;
    end
    if (kind < 70) begin
      q_mag = $urandom >> (32 - $urandom_range(0, 31));
    end else begin
      q_mag = 32'h7FFF_FFFE + $urandom_range(0, 3);
    end
    r_mag = {$urandom, $urandom} % {32'd0, d_abs};
    x_mag = {32'd0, q_mag} * {32'd0, d_abs} + r_mag;
    num   = x_neg ? -x_mag : x_mag;
    den   = y_neg ? -d_abs : d_abs;
    if (kind >= 95) begin
      num = {$urandom, $urandom};
      den = '0;
    end else if (kind >= 80) begin
      num = {$urandom, $urandom};
      den = $urandom;
      if ($urandom_range(0, 7) == 0) num = 64'sh8000_0000_0000_0000;
    end
    send_pair(num, den);
  endtask

  // Drop the request valid so the last pair is not taken again, then wait.
  task automatic drain();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (quot_q.size() != 0) @(posedge clk);
  endtask

  // Corner cases: signs, zero divisor, quotient limits, most negative operands.
  task automatic test_directed();
    tx_gaps_en = 1'b0;
    rx_gaps_en = 1'b0;
    send_pair(64'sd0, 32'sd1);
    send_pair(64'sd7, 32'sd2);
    send_pair(-64'sd7, 32'sd2);
    send_pair(64'sd7, -32'sd2);
    send_pair(-64'sd7, -32'sd2);
    send_pair(64'sd5, 32'sd0);
    send_pair(64'sh8000_0000_0000_0000, 32'sd0);
    send_pair(64'sh7FFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF);
    send_pair(64'sd6442450941, 32'sd3);
    send_pair(-64'sd6442450941, 32'sd3);
    send_pair(-64'sd2147483648, 32'sd1);
    send_pair(64'sd2147483648, -32'sd1);
    send_pair(64'sh8000_0000_0000_0000, -32'sd1);
    send_pair(64'sh8000_0000_0000_0000, 32'sh8000_0000);
    send_pair(64'sh3FFF_FFFF_8000_0000, 32'sh8000_0000);
    send_pair(64'sh7FFF_FFFF_FFFF_FFFF, 32'sh8000_0000);
    send_pair(-64'sd1, 32'sd5);
    send_pair(64'sd3, -32'sd7);
    send_pair(64'sd1, -32'sd1);
    send_pair(64'sh7FFF_FFFF_FFFF_FFFF, 32'sd0);
    drain();
  endtask

  task automatic test_streaming();
    tx_gaps_en = 1'b0;
    rx_gaps_en = 1'b0;
    repeat (400) send_random_pair();
    drain();
  endtask

  task automatic test_random_gaps();
    tx_gaps_en = 1'b1;
    rx_gaps_en = 1'b1;
    repeat (1000) send_random_pair();
    drain();
  endtask

  // Hold the response side off long enough for the pipeline to fill and
  // push back on the request side.
  task automatic test_backpressure();
    tx_gaps_en     = 1'b0;
    rx_gaps_en     = 1'b0;
    rx_hold_cycles = 400;
    repeat (150) send_random_pair();
    drain();
  endtask

  task automatic test_mixed();
    tx_gaps_en = 1'b1;
    rx_gaps_en = 1'b0;
    repeat (120) send_random_pair();
    tx_gaps_en = 1'b0;
    rx_gaps_en = 1'b1;
    repeat (130) send_random_pair();
    drain();
  endtask

  // Response ready: random stalls per transaction, or one long hold-off.
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        @(negedge clk);
        rsp_if.ready = 1'b0;
        repeat (rx_hold_cycles - 1) @(negedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_gaps_en ? $urandom_range(0, 14) : 0;
      @(negedge clk);
      rsp_if.ready = (stall == 0);
      if (stall > 0) begin
        repeat (stall) @(negedge clk);
        rsp_if.ready = 1'b1;
      end
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && req_if.valid && !req_if.ready) req_stall_cycles++;
  end

  always @(posedge clk) begin
    quot_res_t exp_res;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (quot_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: quotient %0d status %0d",
                   rsp_if.quotient, rsp_if.status);
      end else begin
        exp_res = quot_q.pop_front();
        case (exp_res.status)
          sdiv_pkg::SDIV_OK:       ok_cnt++;
          sdiv_pkg::SDIV_DIV_ZERO: div_zero_cnt++;
          sdiv_pkg::SDIV_OVERFLOW: overflow_cnt++;
          default: ;
        endcase
        if (rsp_if.quotient !== exp_res.quotient || rsp_if.status !== exp_res.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: quotient exp %0d got %0d, status exp %0d got %0d",
                     exp_res.quotient, rsp_if.quotient, exp_res.status, rsp_if.status);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.dividend = '0;
    req_if.divisor  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_streaming();
    test_random_gaps();
    test_backpressure();
    test_mixed();

    @(negedge clk);
    req_if.valid = 1'b0;
    drain();
    repeat (40) @(posedge clk);

    $display("checked %0d quotients from %0d operand pairs:",
             results_seen, pairs_sent);
    $display("  %0d ok, %0d divide by zero, %0d overflow",
             ok_cnt, div_zero_cnt, overflow_cnt);
    $display("request side stalled for %0d cycles, %0d mismatches",
             req_stall_cycles, mismatches);
    if (mismatches == 0 && quot_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
